// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CSD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csd assertion failed");

// Checked at every edge, reset included.
`define CSD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("csd assertion failed");

`endif

// File: src/csd_pkg.sv
`default_nettype none
package csd_pkg;

  localparam int MAX_REQ    = 64;
  localparam int CYL_BITS   = 16;
  localparam int SEEK_W     = 18;
  localparam int IDX_W      = $clog2(MAX_REQ);
  localparam int CNT_W      = $clog2(MAX_REQ + 1);
  localparam int KEY_W      = 1 + CYL_BITS + IDX_W;
  localparam int DLT_W      = CYL_BITS + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int DISK_CYL_RESET = 200;
  localparam logic [CYL_BITS-1:0] LASTC_RESET = CYL_BITS'(DISK_CYL_RESET - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_START     = 1'b0,
    CFG_DISK_CYLINDERS = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SWEEP_D,
    ST_SWEEP_A,
    ST_MOVE_D,
    ST_MOVE_A,
    ST_TAIL_D,
    ST_TAIL_A,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic batch_start;
    logic batch_end;
    logic scan_start;
    logic scan_step;
    logic delta_sweep;
    logic delta_move;
    logic acc_add;
    logic cur_zero;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic best_low;
    logic low_started;
    logic final_item;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: src/csd_req_if.sv
`default_nettype none
interface csd_req_if import csd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CYL_BITS-1:0] cylinder;
  logic                last_request;

  modport source (output valid, cylinder, last_request, input ready);
  modport sink (input valid, cylinder, last_request, output ready);
endinterface
`default_nettype wire

// File: src/csd_res_if.sv
`default_nettype none
interface csd_res_if import csd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CYL_BITS-1:0] from_cylinder;
  logic [CYL_BITS-1:0] to_cylinder;
  logic [SEEK_W-1:0]   seek_total;
  logic                dropped;
  logic                last_result;

  modport source (output valid, from_cylinder, to_cylinder, seek_total, dropped, last_result,
                  input ready);
  modport sink (input valid, from_cylinder, to_cylinder, seek_total, dropped, last_result,
                output ready);
endinterface
`default_nettype wire

// File: src/cscan_disk_scheduler.sv
// C-SCAN disk scheduler.
// in_ch carries cylinder requests with valid/ready; a transfer with last_request
// set closes the batch. Requests past the last cylinder are clamped; requests
// beyond the 64-entry store are dropped and flag every result of the batch.
// Configuration (head_start, disk_cylinders) is written through cfg_we/cfg_idx/
// cfg_wdata, one register per cycle; the user must write it only while the
// block is idle, which the block does not enforce. Loading takes one cycle per
// request while in_ch.ready is high. After the closing request, in_ch.ready
// stays low until the last result is placed in the output register. Each
// result takes one selection scan over the n stored requests (one store read
// per cycle, then the last compare), then seek arithmetic (a delta step and an
// add step) and a step to place it, plus a further delta and add step when the
// result carries the sweep to the end and jump to cylinder 0.
// out_ch is a registered output; when out_ch.ready is low the result holds and
// the scheduler waits before placing the next one. in_ch.ready rises again
// in the cycle the final result is placed in the output register.
// Reset (rst_n, synchronous, active low) empties the batch, drops any pending
// result and restores head_start 0 and disk_cylinders 200. The store needs no
// clearing pass.
`default_nettype none
module cscan_disk_scheduler import csd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  csd_req_if.sink                    in_ch,
  csd_res_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  csd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_request),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_cylinder       (in_ch.cylinder),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_from_cylinder (out_ch.from_cylinder),
    .out_to_cylinder   (out_ch.to_cylinder),
    .out_seek_total    (out_ch.seek_total),
    .out_dropped       (out_ch.dropped),
    .out_last_result   (out_ch.last_result)
  );

endmodule
`default_nettype wire

// File: src/csd_ctrl.sv
`default_nettype none
module csd_ctrl import csd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_last,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.batch_start = 1'b1;
            cmd.scan_start  = 1'b1;
            state_nxt       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          // first request below the head start: sweep to the end and jump to 0
          state_nxt = (sts.best_low && !sts.low_started) ? ST_SWEEP_D : ST_MOVE_D;
        end
      end
      ST_SWEEP_D: begin
        cmd.delta_sweep = 1'b1;
        state_nxt       = ST_SWEEP_A;
      end
      ST_SWEEP_A: begin
        cmd.acc_add  = 1'b1;
        cmd.cur_zero = 1'b1;
        state_nxt    = ST_MOVE_D;
      end
      ST_MOVE_D: begin
        cmd.delta_move = 1'b1;
        state_nxt      = ST_MOVE_A;
      end
      ST_MOVE_A: begin
        cmd.acc_add = 1'b1;
        // no lower requests at all: final total carries the sweep and jump
        state_nxt   = (sts.final_item && !sts.best_low) ? ST_TAIL_D : ST_EMIT;
      end
      ST_TAIL_D: begin
        cmd.delta_sweep = 1'b1;
        state_nxt       = ST_TAIL_A;
      end
      ST_TAIL_A: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.final_item) begin
            cmd.batch_end = 1'b1;
            state_nxt     = ST_LOAD;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/csd_dp.sv
`default_nettype none
module csd_dp import csd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  input  wire logic [CYL_BITS-1:0]   in_cylinder,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CYL_BITS-1:0]        out_from_cylinder,
  output logic [CYL_BITS-1:0]        out_to_cylinder,
  output logic [SEEK_W-1:0]          out_seek_total,
  output logic                       out_dropped,
  output logic                       out_last_result
);

  logic [CYL_BITS-1:0] mem [MAX_REQ];

  logic [CYL_BITS-1:0] head_r, lastc_r;
  logic [CYL_BITS-1:0] head_c, in_clamped;

  logic [CNT_W-1:0]    count_r, emit_cnt_r, rd_idx_r;
  logic                overflow_r;
  logic                rd_v_r;
  logic [CYL_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]    rd_pos_r;
  logic                rd_issue;

  logic [KEY_W-1:0]    best_key_r, prev_key_r, cand_key;
  logic                best_valid_r, prev_valid_r;
  logic                cand_take;
  logic [CYL_BITS-1:0] best_cyl;

  logic                low_started_r;
  logic [CYL_BITS-1:0] cur_r, from_r;
  logic [DLT_W-1:0]    delta_r;
  logic [SEEK_W-1:0]   acc_r;

  logic                out_valid_r;
  logic                store_full;

  assign head_c     = (head_r > lastc_r) ? lastc_r : head_r;
  assign in_clamped = (in_cylinder > lastc_r) ? lastc_r : in_cylinder;
  assign store_full = (count_r == CNT_W'(MAX_REQ));
  assign rd_issue   = cmd.scan_step && (rd_idx_r != count_r);

  // sort key: requests below the head start go after all others, ties by slot
  assign cand_key  = {(rd_data_r < head_c), rd_data_r, rd_pos_r};
  assign cand_take = rd_v_r && (!prev_valid_r || (cand_key > prev_key_r))
                            && (!best_valid_r || (cand_key < best_key_r));
  assign best_cyl  = best_key_r[IDX_W +: CYL_BITS];

  assign sts.scan_done   = (rd_idx_r == count_r) && !rd_v_r;
  assign sts.best_low    = best_key_r[KEY_W-1];
  assign sts.low_started = low_started_r;
  assign sts.final_item  = ((emit_cnt_r + CNT_W'(1)) == count_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      lastc_r <= LASTC_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        CFG_HEAD_START:     head_r <= cfg_wdata;
        CFG_DISK_CYLINDERS: lastc_r <= (cfg_wdata == '0) ? '0 : cfg_wdata - CFG_DATA_W'(1);
        default: ;
      endcase
    end
  end

  // request store
  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) begin
      mem[count_r[IDX_W-1:0]] <= in_clamped;
    end
    if (rd_issue) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
      rd_pos_r  <= rd_idx_r[IDX_W-1:0];
    end
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      overflow_r    <= 1'b0;
      rd_idx_r      <= '0;
      rd_v_r        <= 1'b0;
      best_valid_r  <= 1'b0;
      prev_valid_r  <= 1'b0;
      emit_cnt_r    <= '0;
      low_started_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.batch_end) begin
        count_r    <= '0;
        overflow_r <= 1'b0;
      end else if (cmd.load) begin
        if (store_full) begin
          overflow_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
        end
      end

      rd_v_r <= rd_issue;
      if (cmd.scan_start) begin
        rd_idx_r     <= '0;
        best_valid_r <= 1'b0;
      end else begin
        if (rd_issue) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
        if (cand_take) begin
          best_valid_r <= 1'b1;
        end
      end

      if (cmd.batch_start) begin
        prev_valid_r  <= 1'b0;
        emit_cnt_r    <= '0;
        low_started_r <= 1'b0;
      end else begin
        if (cmd.emit) begin
          prev_valid_r <= 1'b1;
          emit_cnt_r   <= emit_cnt_r + CNT_W'(1);
        end
        if (cmd.cur_zero) begin
          low_started_r <= 1'b1;
        end
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cand_take) begin
      best_key_r <= cand_key;
    end
    if (cmd.emit) begin
      prev_key_r        <= best_key_r;
      out_from_cylinder <= from_r;
      out_to_cylinder   <= best_cyl;
      out_seek_total    <= acc_r;
      out_dropped       <= overflow_r;
      out_last_result   <= sts.final_item;
    end

    if (cmd.batch_start) begin
      cur_r <= head_c;
    end else if (cmd.cur_zero) begin
      cur_r <= '0;
    end else if (cmd.delta_move) begin
      cur_r <= best_cyl;
    end

    // distance to the last cylinder and back to 0 is 2*last - cur
    if (cmd.delta_sweep) begin
      delta_r <= {lastc_r, 1'b0} - {1'b0, cur_r};
    end else if (cmd.delta_move) begin
      delta_r <= {1'b0, best_cyl} - {1'b0, cur_r};
      from_r  <= cur_r;
    end

    if (cmd.batch_start) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + SEEK_W'(delta_r);
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: src/csd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module csd_checker import csd_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                in_last,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                out_last,
  input wire logic [CYL_BITS-1:0] out_from,
  input wire logic [CYL_BITS-1:0] out_to,
  input wire logic [SEEK_W-1:0]   out_seek
);

  // a stalled result holds
  `CSD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_from) && $stable(out_to) && $stable(out_seek) && $stable(out_last))

  // no new requests while a batch still has results to come
  `CSD_ASSERT(a_busy_no_load, clk, rst_n, out_valid && !out_last |-> !in_ready)

  // the closing request ends loading; earlier ones produce no result
  `CSD_ASSERT(a_last_closes, clk, rst_n, in_valid && in_ready && in_last |=> !in_ready)
  `CSD_ASSERT(a_mid_no_result, clk, rst_n, in_valid && in_ready && !in_last |=> !$rose(out_valid))

  `CSD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind cscan_disk_scheduler csd_checker u_csd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_request),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_result),
  .out_from  (out_ch.from_cylinder),
  .out_to    (out_ch.to_cylinder),
  .out_seek  (out_ch.seek_total)
);
`default_nettype wire

// File: sim/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csd_pkg::*;

  typedef struct packed {
    logic [CYL_BITS-1:0] cylinder;
    logic                last_request;
  } request_t;

  typedef struct packed {
    logic [CYL_BITS-1:0] from_cyl;
    logic [CYL_BITS-1:0] to_cyl;
    logic [SEEK_W-1:0]   seek_total;
    logic                dropped;
    logic                last_result;
  } move_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  csd_req_if req_ch ();
  csd_res_if res_ch ();

  cscan_disk_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // scheduler state as the testbench sees it
  logic [CFG_DATA_W-1:0] sched_head = '0;
  logic [CFG_DATA_W-1:0] sched_disk = CFG_DATA_W'(DISK_CYL_RESET);
  logic [CYL_BITS-1:0]   batch_q[$];
  logic                  batch_overflow = 1'b0;

  request_t pending_requests[$];
  move_t    expected_moves[$];

  int  errors = 0;
  int  req_gap = 0;
  int  res_gap = 0;
  logic req_idle = 1'b1;
  logic res_idle = 1'b1;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [CYL_BITS-1:0] last_cylinder();
    return (sched_disk == 0) ? '0 : CYL_BITS'(sched_disk - 1);
  endfunction

  // Builds the C-SCAN service order of the closed batch.
  task automatic schedule_batch(input logic [CYL_BITS-1:0] lastc);
    logic [CYL_BITS-1:0] sorted[$];
    logic [CYL_BITS-1:0] head;
    logic [CYL_BITS-1:0] cur;
    logic [CYL_BITS-1:0] v;
    logic [SEEK_W-1:0]   seek;
    int                  n_low;
    int                  n_high;
    int                  j;
    move_t               mv;
    sorted = {};
    foreach (batch_q[i]) begin
      v = batch_q[i];
      j = sorted.size();
      while (j > 0 && sorted[j-1] > v) j--;
      sorted.insert(j, v);
    end
    head = (sched_head > lastc) ? lastc : sched_head;
    n_low = 0;
    foreach (sorted[i]) if (sorted[i] < head) n_low++;
    n_high = sorted.size() - n_low;
    cur = head;
    seek = '0;
    mv.dropped = batch_overflow;
    foreach (sorted[i]) begin
      if (sorted[i] >= head) begin
        mv.from_cyl = cur;
        mv.to_cyl = sorted[i];
        seek = seek + SEEK_W'(sorted[i] - cur);
        cur = sorted[i];
        n_high--;
        mv.last_result = (n_high == 0 && n_low == 0);
        // no lower requests: the sweep and jump land on the final result
        if (mv.last_result) seek = seek + SEEK_W'(lastc - cur) + SEEK_W'(lastc);
        mv.seek_total = seek;
        expected_moves.push_back(mv);
      end
    end
    if (n_low > 0) seek = seek + SEEK_W'(lastc - cur) + SEEK_W'(lastc);
    cur = '0;
    foreach (sorted[i]) begin
      if (sorted[i] < head) begin
        mv.from_cyl = cur;
        mv.to_cyl = sorted[i];
        seek = seek + SEEK_W'(sorted[i] - cur);
        cur = sorted[i];
        n_low--;
        mv.last_result = (n_low == 0);
        mv.seek_total = seek;
        expected_moves.push_back(mv);
      end
    end
    batch_q = {};
    batch_overflow = 1'b0;
  endtask

  task automatic absorb_request(input request_t rq);
    logic [CYL_BITS-1:0] lastc;
    logic [CYL_BITS-1:0] c;
    lastc = last_cylinder();
    c = (rq.cylinder > lastc) ? lastc : rq.cylinder;
    if (batch_q.size() < MAX_REQ) batch_q.push_back(c);
    else batch_overflow = 1'b1;
    if (rq.last_request) schedule_batch(lastc);
  endtask

  task automatic note_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // request driver
  always @(posedge clk) begin
    logic send;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      req_ch.cylinder <= '0;
      req_ch.last_request <= 1'b0;
      req_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        absorb_request(pending_requests.pop_front());
        req_gap = req_idle ? $urandom_range(0, 19) : 0;
      end
      send = 1'b0;
      if (pending_requests.size() != 0) begin
        if (req_gap > 0) req_gap--;
        else send = 1'b1;
      end
      req_ch.valid <= send;
      if (send) begin
        req_ch.cylinder <= pending_requests[0].cylinder;
        req_ch.last_request <= pending_requests[0].last_request;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    move_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      res_gap = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_moves.size() == 0) begin
          note_mismatch($sformatf("unexpected transfer %0d -> %0d",
                                  res_ch.from_cylinder, res_ch.to_cylinder));
        end else begin
          want = expected_moves.pop_front();
          compare_field("from_cylinder", 32'(res_ch.from_cylinder), 32'(want.from_cyl));
          compare_field("to_cylinder", 32'(res_ch.to_cylinder), 32'(want.to_cyl));
          compare_field("seek_total", 32'(res_ch.seek_total), 32'(want.seek_total));
          compare_field("dropped", 32'(res_ch.dropped), 32'(want.dropped));
          compare_field("last_result", 32'(res_ch.last_result), 32'(want.last_result));
        end
        res_gap = res_idle ? $urandom_range(0, 19) : 0;
      end
      if (res_gap > 0) begin
        res_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_request(input logic [CYL_BITS-1:0] cyl, input logic last);
    request_t rq;
    rq.cylinder = cyl;
    rq.last_request = last;
    pending_requests.push_back(rq);
  endtask

  function automatic logic [CYL_BITS-1:0] random_cylinder();
    int unsigned span;
    // one past the last cylinder so clamping shows up often
    span = (sched_disk == 0) ? 1 : sched_disk;
    case ($urandom_range(0, 7))
      0: return CYL_BITS'($urandom);
      1: return '0;
      2: return CYL_BITS'(sched_head);
      default: return CYL_BITS'($urandom_range(0, span));
    endcase
  endfunction

  task automatic enqueue_batch(input int n);
    for (int k = 0; k < n; k++) push_request(random_cylinder(), k == n - 1);
  endtask

  // block must be idle before any register write
  task automatic drain();
    while (pending_requests.size() != 0 || expected_moves.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HEAD_START) sched_head = value;
    else sched_disk = value;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] hs, input logic [CFG_DATA_W-1:0] dc);
    write_reg(CFG_HEAD_START, hs);
    write_reg(CFG_DISK_CYLINDERS, dc);
    @(negedge clk);
  endtask

  task automatic pick_config(input int p);
    logic [CFG_DATA_W-1:0] hs;
    logic [CFG_DATA_W-1:0] dc;
    case (p)
      0: begin
        hs = '0;
        dc = '1;
      end
      1: begin
        hs = '1;
        dc = '1;
      end
      2: begin
        hs = CFG_DATA_W'($urandom);
        dc = '0;
      end
      3: begin
        hs = '0;
        dc = 16'd1;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: dc = '1;
          1: dc = CFG_DATA_W'($urandom);
          default: dc = CFG_DATA_W'($urandom_range(1, 300));
        endcase
        if ($urandom_range(0, 3) == 0) hs = CFG_DATA_W'($urandom);
        else hs = CFG_DATA_W'($urandom_range(0, dc + 5));
      end
    endcase
    set_config(hs, dc);
  endtask

  initial begin
    int phase;
    int random_items;
    int n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_HEAD_START;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: head at 0, 200 cylinders; the first request clamps
    push_request(16'hFFFF, 1'b1);
    push_request(16'h0000, 1'b1);
    drain();
    set_config(16'd100, 16'd200);
    push_request(16'd150, 1'b0);
    push_request(16'd50, 1'b0);
    push_request(16'd100, 1'b0);
    push_request(16'd0, 1'b0);
    push_request(16'd199, 1'b1);
    push_request(16'd30, 1'b0);
    push_request(16'd10, 1'b1);
    drain();
    // zero-size disk, head past the end
    set_config(16'hFFFF, 16'd0);
    push_request(16'd5, 1'b0);
    push_request(16'hFFFF, 1'b0);
    push_request(16'd0, 1'b1);
    drain();
    set_config(16'hFFFF, 16'hFFFF);
    push_request(16'd0, 1'b0);
    push_request(16'hFFFF, 1'b0);
    push_request(16'hFFFE, 1'b0);
    push_request(16'd1, 1'b1);
    drain();
    set_config(16'd0, 16'd1);
    push_request(16'd1, 1'b0);
    push_request(16'd0, 1'b1);
    drain();
    set_config(16'd7, 16'd2);
    push_request(16'd0, 1'b0);
    push_request(16'd1, 1'b1);

    phase = 0;
    random_items = 0;
    while (random_items < 90) begin
      drain();
      pick_config(phase);
      req_idle = ($urandom_range(0, 3) != 0);
      res_idle = ($urandom_range(0, 3) != 0);
      // one batch overfills the store, its closing request dropped too
      if (phase == 1) begin
        n = 65 + $urandom_range(0, 2);
        enqueue_batch(n);
        random_items += n;
      end
      repeat ($urandom_range(1, 3)) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        enqueue_batch(n);
        random_items += n;
      end
      phase++;
    end

    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
`default_nettype wire
